// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_front, tcw_back, text_console_writer and both testbench files.
package tcw_pkg;

  localparam int KIND_W     = 2;
  localparam int CODE_W     = 8;
  localparam int ADDR_IN_W  = 11;
  localparam int COLOR_W    = 4;
  localparam int WORD_W     = 16;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int POS_OUT_W  = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [WORD_W-1:0] CELL_RESET = {8'h00, CODE_SPACE};

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_CR,
    OP_LF,
    OP_READ,
    OP_READ_OOR,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CODE_W-1:0]    code;
    logic [ADDR_IN_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic init_done;
    logic rd_issue;
  } bk_stat_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// Top level of the text console writer: COLUMNS x ROWS character cells.
// Depends on tcw_pkg, tcw_front, tcw_back and tcw_ram.
//
// Input beats carry a kind (put character, read cell, clear screen), a
// character code and a read address. Every input beat gives exactly one
// result beat with the cursor column, row and linear position after the
// item, plus the cell word for reads (zero otherwise). Color registers are
// written on the cfg channel, which is always ready.
// A two-entry queue sits between the front end and the back end; the result
// sits in an output register, so new input is taken while a result waits.
// Characters, CR and LF pass the back end at one item per cycle while the
// output is free and no fill is running; a read also holds the back end in
// S_READ for the registered cell RAM data. A put at a pending wrap first
// takes a step that only advances the line. A scroll walks the new bottom
// row through the cell RAM write port; a clear walks all cells. The queue
// keeps filling meanwhile. After reset, in_ready stays low while every cell
// is written with a space. A stalled output stops the back end; the queue
// then fills and in_ready drops.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]        in_kind,
  input  logic [tcw_pkg::CODE_W-1:0]        in_char_code,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]     in_read_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcw_pkg::COL_OUT_W-1:0]     out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     out_cursor_row,
  output logic [tcw_pkg::POS_OUT_W-1:0]     out_cursor_pos,
  output logic [tcw_pkg::WORD_W-1:0]        out_read_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data
);

  tcw_pkg::cfg_wr_t  cfg;
  tcw_pkg::bk_stat_t stat;
  tcw_pkg::item_t    q_item;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tcw_front #(
    .CELLS (COLUMNS * ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_char_code    (in_char_code),
    .in_read_address (in_read_address),
    .init_done       (stat.init_done),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cursor_pos (out_cursor_pos),
    .out_read_data  (out_read_data),
    .stat           (stat)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("input taken before the cell store was cleared");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.rd_issue |-> ##2 out_valid)
    else $error("cell read gave no result beat");

endmodule

// ===== rtl/core/tcw_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tcw_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and queues them two deep.
// Depends on tcw_pkg.
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]            in_kind,
  input  logic [tcw_pkg::CODE_W-1:0]            in_char_code,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]         in_read_address,
  input  logic                                  init_done,
  output logic                                  q_valid,
  output tcw_pkg::item_t                        q_item,
  input  logic                                  q_pop
);

  localparam logic [1:0] QDEPTH = 2'd2;

  tcw_pkg::item_t slot_r [2];
  tcw_pkg::item_t item;
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;

  always_comb begin
    item.code = in_char_code;
    item.addr = in_read_address;
    case (in_kind)
      tcw_pkg::KIND_PUT: begin
        if (in_char_code == tcw_pkg::CODE_CR) begin
          item.op = tcw_pkg::OP_CR;
        end else if (in_char_code == tcw_pkg::CODE_LF) begin
          item.op = tcw_pkg::OP_LF;
        end else begin
          item.op = tcw_pkg::OP_CHAR;
        end
      end
      tcw_pkg::KIND_READ: begin
        item.op = (32'(in_read_address) < CELLS) ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_OOR;
      end
      tcw_pkg::KIND_CLEAR: begin
        item.op = tcw_pkg::OP_CLEAR;
      end
      default: begin
        item.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

  assign in_ready = init_done && (count_r != QDEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== rtl/core/tcw_back.sv =====
`timescale 1ns / 1ps
// Back end: cursor, color registers, cell store with row rotation, fill
// sequencer and result register. Depends on tcw_pkg and tcw_ram.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_pkg::cfg_wr_t                  cfg,
  input  logic                              q_valid,
  input  tcw_pkg::item_t                    q_item,
  output logic                              q_pop,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [tcw_pkg::COL_OUT_W-1:0]     out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     out_cursor_row,
  output logic [tcw_pkg::POS_OUT_W-1:0]     out_cursor_pos,
  output logic [tcw_pkg::WORD_W-1:0]        out_read_data,
  output tcw_pkg::bk_stat_t                 stat
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int OCOL_W = tcw_pkg::COL_OUT_W;
  localparam int OROW_W = tcw_pkg::ROW_OUT_W;
  localparam int OPOS_W = tcw_pkg::POS_OUT_W;
  localparam int WORD_W = tcw_pkg::WORD_W;

  localparam logic [ADDR_W:0]   CELLS_EXT  = (ADDR_W + 1)'(CELLS);
  localparam logic [COL_W-1:0]  COL_END    = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [POS_W-1:0]  POS_BOTTOM = POS_W'((ROWS - 1) * COLUMNS);
  localparam logic [POS_W-1:0]  POS_STEP   = POS_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] CNT_ALL    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] CNT_ROW    = ADDR_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_FILL, S_READ} state_t;

  state_t                           state_r, state_nxt;
  logic [COL_W-1:0]                 col_r, col_nxt;
  logic [ROW_W-1:0]                 row_r, row_nxt;
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [ADDR_W-1:0]                base_r, base_nxt;
  logic [ADDR_W-1:0]                fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0]                fill_cnt_r, fill_cnt_nxt;
  logic [WORD_W-1:0]                fill_word_r, fill_word_nxt;
  logic [tcw_pkg::COLOR_W-1:0]      fg_r, fg_nxt;
  logic [tcw_pkg::COLOR_W-1:0]      bg_r, bg_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [OCOL_W-1:0]                out_col_r, out_col_nxt;
  logic [OROW_W-1:0]                out_row_r, out_row_nxt;
  logic [OPOS_W-1:0]                out_pos_r, out_pos_nxt;
  logic [WORD_W-1:0]                out_data_r, out_data_nxt;

  logic                             mem_we;
  logic [ADDR_W-1:0]                mem_waddr;
  logic [WORD_W-1:0]                mem_wdata;
  logic [ADDR_W-1:0]                mem_raddr;
  logic [WORD_W-1:0]                mem_rdata;
  logic [WORD_W-1:0]                blank;
  logic [WORD_W-1:0]                emit_data;
  logic                             slot_free;
  logic                             is_put;
  logic                             do_nl;
  logic                             emit;
  logic                             rd_issue;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CELLS_EXT) begin
      s = s - CELLS_EXT;
    end
    return s[ADDR_W-1:0];
  endfunction

  tcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign blank     = {bg_r, fg_r, tcw_pkg::CODE_SPACE};
  assign slot_free = !out_valid_r || out_ready;
  assign is_put    = (q_item.op == tcw_pkg::OP_CHAR) || (q_item.op == tcw_pkg::OP_CR) ||
                     (q_item.op == tcw_pkg::OP_LF);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    base_nxt      = base_r;
    fill_addr_nxt = fill_addr_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_word_nxt = fill_word_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_addr_r;
    mem_wdata     = fill_word_r;
    mem_raddr     = wrap_add(ADDR_W'(q_item.addr), base_r);
    q_pop         = 1'b0;
    do_nl         = 1'b0;
    emit          = 1'b0;
    emit_data     = '0;
    rd_issue      = 1'b0;

    if (cfg.valid) begin
      case (cfg.index)
        tcw_pkg::CFG_FG: fg_nxt = cfg.data;
        tcw_pkg::CFG_BG: bg_nxt = cfg.data;
        default: ;
      endcase
    end

    case (state_r)
      S_INIT, S_FILL: begin
        mem_we        = 1'b1;
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        fill_cnt_nxt  = fill_cnt_r - ADDR_W'(1);
        if (fill_cnt_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_data = mem_rdata;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && slot_free) begin
          if (is_put && (col_r == COL_END)) begin
            do_nl = 1'b1;
          end else begin
            q_pop = 1'b1;
            emit  = 1'b1;
            case (q_item.op)
              tcw_pkg::OP_CHAR: begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(pos_r[ADDR_W-1:0], base_r);
                mem_wdata = {bg_r, fg_r, q_item.code};
                col_nxt   = col_r + COL_W'(1);
                pos_nxt   = pos_r + POS_W'(1);
              end
              tcw_pkg::OP_CR: begin
                col_nxt = '0;
                pos_nxt = pos_r - POS_W'(col_r);
              end
              tcw_pkg::OP_LF: begin
                do_nl = 1'b1;
              end
              tcw_pkg::OP_READ: begin
                emit      = 1'b0;
                rd_issue  = 1'b1;
                state_nxt = S_READ;
              end
              tcw_pkg::OP_CLEAR: begin
                col_nxt       = '0;
                row_nxt       = '0;
                pos_nxt       = '0;
                base_nxt      = '0;
                fill_addr_nxt = '0;
                fill_cnt_nxt  = CNT_ALL;
                fill_word_nxt = blank;
                state_nxt     = S_FILL;
              end
              default: ;
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // advance to the next line; on the last row, rotate the store and blank the new bottom row
    if (do_nl) begin
      col_nxt = '0;
      if (row_r == ROW_LAST) begin
        pos_nxt       = POS_BOTTOM;
        base_nxt      = wrap_add(base_r, ROW_STEP);
        fill_addr_nxt = base_r;
        fill_cnt_nxt  = CNT_ROW;
        fill_word_nxt = blank;
        state_nxt     = S_FILL;
      end else begin
        row_nxt = row_r + ROW_W'(1);
        pos_nxt = pos_r - POS_W'(col_r) + POS_STEP;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = OCOL_W'(col_nxt);
      out_row_nxt   = OROW_W'(row_nxt);
      out_pos_nxt   = OPOS_W'(pos_nxt);
      out_data_nxt  = emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      base_r      <= '0;
      fill_addr_r <= '0;
      fill_cnt_r  <= CNT_ALL;
      fill_word_r <= tcw_pkg::CELL_RESET;
      fg_r        <= tcw_pkg::FG_RESET;
      bg_r        <= tcw_pkg::BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      base_r      <= base_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_word_r <= fill_word_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_pos = out_pos_r;
  assign out_read_data  = out_data_r;

  assign stat.init_done = (state_r != S_INIT);
  assign stat.rd_issue  = rd_issue;

endmodule

// ===== test/text_console_writer_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the text console writer: keeps its own copy of the cell store,
// the cursor and the colors, and compares every result beat with its prediction.
// Depends on tcw_pkg; instantiated by text_console_writer_tb beside the block.
module text_console_writer_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]        in_kind,
  input  logic [tcw_pkg::CODE_W-1:0]        in_char_code,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]     in_read_address,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [tcw_pkg::COL_OUT_W-1:0]     out_cursor_col,
  input  logic [tcw_pkg::ROW_OUT_W-1:0]     out_cursor_row,
  input  logic [tcw_pkg::POS_OUT_W-1:0]     out_cursor_pos,
  input  logic [tcw_pkg::WORD_W-1:0]        out_read_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data,
  output int                                mismatches,
  output int                                outstanding
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] pos;
    logic [WORD_W-1:0]    data;
  } cursor_report_t;

  logic [WORD_W-1:0]  screen [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  cursor_report_t     expected_reports [$];
  int                 fail_total;

  function automatic logic [WORD_W-1:0] cell_word(input logic [CODE_W-1:0] code);
    return {bg_color, fg_color, code};
  endfunction

  task automatic new_line();
    logic [WORD_W-1:0] blank;
    blank = cell_word(CODE_SPACE);
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int x = 0; x < COLUMNS; x++) screen[CELLS - COLUMNS + x] = blank;
      cur_row = ROWS - 1;
    end
  endtask

  task automatic console_step(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                              input logic [ADDR_IN_W-1:0] addr, output cursor_report_t rep);
    logic [WORD_W-1:0] word;
    int                pos;
    word = '0;
    case (kind)
      KIND_PUT: begin
        if (cur_col >= COLUMNS) new_line();
        if (code == CODE_CR) begin
          cur_col = 0;
        end else if (code == CODE_LF) begin
          new_line();
        end else begin
          screen[cur_row * COLUMNS + cur_col] = cell_word(code);
          cur_col++;
        end
      end
      KIND_READ: begin
        if (addr < CELLS) word = screen[addr];
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = cell_word(CODE_SPACE);
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    pos = cur_row * COLUMNS + cur_col;
    rep.col  = cur_col[COL_OUT_W-1:0];
    rep.row  = cur_row[ROW_OUT_W-1:0];
    rep.pos  = pos[POS_OUT_W-1:0];
    rep.data = word;
  endtask

  task automatic report(input string what, input int want, input int got);
    $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, want, got);
    fail_total++;
  endtask

  initial fail_total = 0;

  always @(posedge clk) begin
    cursor_report_t rep;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = CELL_RESET;
      cur_col  = 0;
      cur_row  = 0;
      fg_color = FG_RESET;
      bg_color = BG_RESET;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report("unexpected result beat, cursor_pos", -1, int'(out_cursor_pos));
        end else begin
          rep = expected_reports.pop_front();
          if (out_cursor_col != rep.col)
            report("cursor_col", int'(rep.col), int'(out_cursor_col));
          if (out_cursor_row != rep.row)
            report("cursor_row", int'(rep.row), int'(out_cursor_row));
          if (out_cursor_pos != rep.pos)
            report("cursor_pos", int'(rep.pos), int'(out_cursor_pos));
          if (out_read_data != rep.data)
            report("read_data", int'(rep.data), int'(out_read_data));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FG:  fg_color = cfg_data;
          CFG_BG:  bg_color = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        console_step(in_kind, in_char_code, in_read_address, rep);
        expected_reports.push_back(rep);
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_reports.size();
  end

endmodule

// ===== test/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// Top of the text console writer testbench: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, text_console_writer and text_console_writer_checker.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int PHASES  = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [KIND_W-1:0]    in_kind;
  logic [CODE_W-1:0]    in_char_code;
  logic [ADDR_IN_W-1:0] in_read_address;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COL_OUT_W-1:0] out_cursor_col;
  logic [ROW_OUT_W-1:0] out_cursor_row;
  logic [POS_OUT_W-1:0] out_cursor_pos;
  logic [WORD_W-1:0]    out_read_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;

  int mismatches;
  int outstanding;
  int send_idle = 6;
  int recv_idle = 74;
  int items_sent = 0;
  int cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_i (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_writer test failed");
      $finish;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [ADDR_IN_W-1:0] addr);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_char_code    <= code;
    in_read_address <= addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [ADDR_IN_W-1:0] any_addr();
    return ADDR_IN_W'($urandom);
  endfunction

  function automatic logic [ADDR_IN_W-1:0] read_target();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)  return ADDR_IN_W'($urandom_range(CELLS, 2**ADDR_IN_W - 1));
    if (pick < 35) return ADDR_IN_W'($urandom_range((ROWS - 3) * COLUMNS, CELLS - 1));
    return ADDR_IN_W'($urandom_range(0, CELLS - 1));
  endfunction

  task automatic put_text_line();
    int len;
    int term;
    len = ($urandom_range(99) < 80) ? $urandom_range(0, 60) : $urandom_range(70, 170);
    repeat (len) begin
      if ($urandom_range(99) < 80) send_item(KIND_PUT, CODE_W'($urandom_range(8'h20, 8'h7e)),
                                             any_addr());
      else send_item(KIND_PUT, CODE_W'($urandom), any_addr());
    end
    term = $urandom_range(99);
    if (term < 50) begin
      send_item(KIND_PUT, CODE_CR, any_addr());
      send_item(KIND_PUT, CODE_LF, any_addr());
    end else if (term < 80) begin
      send_item(KIND_PUT, CODE_LF, any_addr());
    end else if (term < 90) begin
      send_item(KIND_PUT, CODE_CR, any_addr());
    end
  endtask

  task automatic settle();
    while (outstanding != 0) @(posedge clk);
    // a scroll or clear may still be walking the store
    repeat (CELLS + 100) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0] fg_set [PHASES];
    logic [COLOR_W-1:0] bg_set [PHASES];
    int pick;
    fg_set = '{4'd0, 4'd15, 4'd0, 4'd7, 4'd0, 4'd15};
    bg_set = '{4'd15, 4'd15, 4'd0, 4'd8, 4'd0, 4'd0};
    fg_set[4] = COLOR_W'($urandom);
    bg_set[4] = COLOR_W'($urandom);
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_PUT;
    in_char_code    = '0;
    in_read_address = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_FG;
    cfg_data        = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset colors and store, edge codes, controls, unused kind, clear
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hff, 11'(CELLS - 1));
    send_item(KIND_READ, 8'h00, 11'(CELLS));
    send_item(KIND_READ, 8'hff, 11'h7ff);
    send_item(KIND_PUT, 8'h41, 11'h000);
    send_item(KIND_PUT, 8'hff, 11'h7ff);
    send_item(KIND_PUT, 8'h00, 11'h000);
    send_item(KIND_PUT, 8'h80, 11'h555);
    send_item(KIND_PUT, CODE_CR, 11'h2aa);
    send_item(KIND_PUT, CODE_LF, 11'h000);
    send_item(KIND_UNUSED, 8'hff, 11'h7ff);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd1);
    send_item(KIND_READ, 8'h00, 11'd2);
    send_item(KIND_READ, 8'h00, 11'd3);
    send_item(KIND_CLEAR, 8'h00, 11'h000);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_PUT, 8'h7e, 11'h000);

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      settle();
      if (ph < 2) begin
        send_idle = 6;
        recv_idle = 74;
      end else if (ph < 4) begin
        send_idle = 74;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      cfg_write(CFG_FG, fg_set[ph]);
      cfg_write(CFG_BG, bg_set[ph]);
      cfg_valid <= 1'b0;
      @(negedge clk);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          put_text_line();
        end else if (pick < 83) begin
          repeat ($urandom_range(1, 4)) send_item(KIND_READ, CODE_W'($urandom), read_target());
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 30)) send_item(KIND_PUT, CODE_LF, any_addr());
        end else if (pick < 91) begin
          send_item(KIND_CLEAR, CODE_W'($urandom), any_addr());
        end else begin
          repeat ($urandom_range(1, 5))
            send_item(KIND_W'($urandom), CODE_W'($urandom), any_addr());
        end
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end

endmodule

// ===== text_console_writer.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
test/text_console_writer_checker.sv
test/text_console_writer_tb.sv
